// ===== rtl/pdi_pkg.sv =====
// Shared constants, types and helpers for the pairwise dot interaction block.
// Used by every module under rtl except pdi_ram; depends on nothing else.

package pdi_pkg;

   localparam int MAX_VECTORS = 32;
   localparam int MAX_WIDTH   = 128;

   localparam int VEC_BITS    = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int ELEM_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW_BITS     = ELEM_BITS + 1;
   localparam int STORE_DEPTH = MAX_VECTORS * MAX_WIDTH;
   localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam int DATA_W      = 16;
   localparam int PROD_W      = 32;
   localparam int ACC_W       = 48;
   localparam int FRAC_SHIFT  = 12;

   localparam int WIDTH_REG_W = 8;
   localparam int NEMB_REG_W  = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 8'd16;
   localparam logic [NEMB_REG_W-1:0]  NEMB_RESET  = 5'd26;

   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_WIDTH   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_EMBEDDINGS = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                issue;
      logic                first;
      logic [VEC_BITS-1:0] index;
      logic [DATA_W-1:0]   x;
   } mac_ctrl_type;

   function automatic logic [ADDR_BITS-1:0] store_addr(input logic [VEC_BITS-1:0]  v,
                                                       input logic [ELEM_BITS-1:0] e);
      return ADDR_BITS'(v) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(e);
   endfunction

endpackage

// ===== rtl/pdi_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.

module pdi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/pdi_mac.sv =====
// Shared multiply-accumulate unit and the per-vector pair accumulators.
// Depends on pdi_pkg; fed by the sequencer and the vector store read port.

module pdi_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  pdi_pkg::mac_ctrl_type               ctrl,
   input  logic [pdi_pkg::DATA_W-1:0]          store_rdata,
   output logic [pdi_pkg::ACC_W-1:0]           acc_rdata,
   output logic                                pipe_busy
);

   localparam int AW = pdi_pkg::ACC_W;
   localparam int PW = pdi_pkg::PROD_W;

   logic                          s1_valid_ff;
   logic                          s1_first_ff;
   logic [pdi_pkg::VEC_BITS-1:0]  s1_index_ff;
   logic                          s2_valid_ff;
   logic                          s2_first_ff;
   logic [pdi_pkg::VEC_BITS-1:0]  s2_index_ff;
   logic signed [PW-1:0]          prod_ff;
   logic signed [PW-1:0]          prod_in;
   logic [AW-1:0]                 acc_sum_in;
   logic [AW-1:0]                 acc_ff [pdi_pkg::MAX_VECTORS];

   always_comb begin
      prod_in    = $signed(ctrl.x) * $signed(store_rdata);
      acc_sum_in = (s2_first_ff ? AW'(0) : acc_ff[s2_index_ff]) + AW'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctrl.issue;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_first_ff <= ctrl.first;
      s1_index_ff <= ctrl.index;
      s2_first_ff <= s1_first_ff;
      s2_index_ff <= s1_index_ff;
      prod_ff     <= prod_in;
      if (s2_valid_ff) begin
         acc_ff[s2_index_ff] <= acc_sum_in;
      end
   end

   assign acc_rdata = acc_ff[ctrl.index];
   assign pipe_busy = s1_valid_ff | s2_valid_ff;

endmodule

// ===== rtl/pdi_seq.sv =====
// Sequencer: configuration registers, sample counters, store addressing and
// result registers. Depends on pdi_pkg; drives pdi_ram and pdi_mac.

module pdi_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pdi_pkg::DATA_W-1:0]          req_element_value,
   input  logic                                csr_we,
   input  logic [pdi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pdi_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                ram_we,
   output logic [pdi_pkg::ADDR_BITS-1:0]       ram_waddr,
   output logic [pdi_pkg::DATA_W-1:0]          ram_wdata,
   output logic [pdi_pkg::ADDR_BITS-1:0]       ram_raddr,
   output pdi_pkg::mac_ctrl_type               mac_ctrl,
   input  logic                                pipe_busy,
   input  logic [pdi_pkg::ACC_W-1:0]           acc_rdata,
   output logic                                rsp_valid,
   output logic [pdi_pkg::ACC_W-1:0]           rsp_result_value,
   output logic                                rsp_is_pair,
   output logic                                rsp_last
);

   localparam int VB = pdi_pkg::VEC_BITS;
   localparam int EB = pdi_pkg::ELEM_BITS;
   localparam int EW = pdi_pkg::EW_BITS;
   localparam int NB = pdi_pkg::NEMB_REG_W;
   localparam int AW = pdi_pkg::ACC_W;
   localparam int DW = pdi_pkg::DATA_W;
   localparam int XW = AW - DW - pdi_pkg::FRAC_SHIFT;

   pdi_pkg::state_type state_ff, state_in;

   logic [pdi_pkg::WIDTH_REG_W-1:0] width_ff, width_in;
   logic [NB-1:0]                   nemb_ff, nemb_in;
   logic [VB-1:0]                   vec_cnt_ff, vec_cnt_in;
   logic [EB-1:0]                   elem_cnt_ff, elem_cnt_in;
   logic [VB-1:0]                   item_v_ff, item_v_in;
   logic [EB-1:0]                   item_e_ff, item_e_in;
   logic [DW-1:0]                   x_ff, x_in;
   logic                            end_vec_ff, end_vec_in;
   logic                            end_sample_ff, end_sample_in;
   logic [VB-1:0]                   idx_ff, idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]                   rsp_value_ff, rsp_value_in;
   logic                            rsp_is_pair_ff, rsp_is_pair_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic          accept;
   logic [EW-1:0] eff_width;
   logic [NB-1:0] eff_nemb;
   logic          end_vec_now;
   logic          end_sample_now;
   logic          idx_at_end;

   always_comb begin
      accept = start && (state_ff == pdi_pkg::ST_IDLE);

      if (width_ff == '0) begin
         eff_width = EW'(1);
      end else if (32'(width_ff) > 32'(pdi_pkg::MAX_WIDTH)) begin
         eff_width = EW'(pdi_pkg::MAX_WIDTH);
      end else begin
         eff_width = EW'(width_ff);
      end

      if (nemb_ff == '0) begin
         eff_nemb = NB'(1);
      end else if (32'(nemb_ff) > 32'(pdi_pkg::MAX_VECTORS - 1)) begin
         eff_nemb = NB'(pdi_pkg::MAX_VECTORS - 1);
      end else begin
         eff_nemb = nemb_ff;
      end

      end_vec_now    = (EW'(elem_cnt_ff) + EW'(1)) >= eff_width;
      end_sample_now = end_vec_now && (32'(vec_cnt_ff) >= 32'(eff_nemb));
      idx_at_end     = (idx_ff + VB'(1)) == item_v_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pdi_pkg::ST_IDLE: begin
            if (accept && (vec_cnt_ff != '0)) begin
               state_in = pdi_pkg::ST_MAC;
            end
         end
         pdi_pkg::ST_MAC: begin
            if (idx_at_end) begin
               state_in = pdi_pkg::ST_DRAIN;
            end
         end
         pdi_pkg::ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = end_vec_ff ? pdi_pkg::ST_EMIT : pdi_pkg::ST_IDLE;
            end
         end
         pdi_pkg::ST_EMIT: begin
            if (idx_at_end) begin
               state_in = pdi_pkg::ST_IDLE;
            end
         end
         default: state_in = pdi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      width_in       = width_ff;
      nemb_in        = nemb_ff;
      vec_cnt_in     = vec_cnt_ff;
      elem_cnt_in    = elem_cnt_ff;
      item_v_in      = item_v_ff;
      item_e_in      = item_e_ff;
      x_in           = x_ff;
      end_vec_in     = end_vec_ff;
      end_sample_in  = end_sample_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_value_in   = rsp_value_ff;
      rsp_is_pair_in = rsp_is_pair_ff;
      rsp_last_in    = rsp_last_ff;
      ram_we         = 1'b0;
      ram_waddr      = pdi_pkg::store_addr(vec_cnt_ff, elem_cnt_ff);
      ram_wdata      = req_element_value;
      ram_raddr      = pdi_pkg::store_addr(idx_ff, item_e_ff);
      mac_ctrl.issue = 1'b0;
      mac_ctrl.first = (item_e_ff == '0);
      mac_ctrl.index = idx_ff;
      mac_ctrl.x     = x_ff;

      if (csr_we && (csr_index == pdi_pkg::CSR_VECTOR_WIDTH)) begin
         width_in = csr_wdata[pdi_pkg::WIDTH_REG_W-1:0];
      end
      if (csr_we && (csr_index == pdi_pkg::CSR_NUM_EMBEDDINGS)) begin
         nemb_in = csr_wdata[NB-1:0];
      end

      unique case (state_ff)
         pdi_pkg::ST_IDLE: begin
            if (accept) begin
               ram_we        = 1'b1;
               x_in          = req_element_value;
               item_v_in     = vec_cnt_ff;
               item_e_in     = elem_cnt_ff;
               end_vec_in    = end_vec_now;
               end_sample_in = end_sample_now;
               idx_in        = '0;
               if (end_vec_now) begin
                  elem_cnt_in = '0;
                  vec_cnt_in  = end_sample_now ? '0 : vec_cnt_ff + VB'(1);
               end else begin
                  elem_cnt_in = elem_cnt_ff + EB'(1);
               end
               if (vec_cnt_ff == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_value_in   = {{XW{req_element_value[DW-1]}}, req_element_value,
                                    {pdi_pkg::FRAC_SHIFT{1'b0}}};
                  rsp_is_pair_in = 1'b0;
                  rsp_last_in    = 1'b0;
               end
            end
         end
         pdi_pkg::ST_MAC: begin
            mac_ctrl.issue = 1'b1;
            idx_in         = idx_ff + VB'(1);
         end
         pdi_pkg::ST_DRAIN: begin
            idx_in = '0;
         end
         pdi_pkg::ST_EMIT: begin
            rsp_valid_in   = 1'b1;
            rsp_value_in   = acc_rdata;
            rsp_is_pair_in = 1'b1;
            rsp_last_in    = end_sample_ff && idx_at_end;
            idx_in         = idx_ff + VB'(1);
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdi_pkg::ST_IDLE;
         width_ff     <= pdi_pkg::WIDTH_RESET;
         nemb_ff      <= pdi_pkg::NEMB_RESET;
         vec_cnt_ff   <= '0;
         elem_cnt_ff  <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         nemb_ff      <= nemb_in;
         vec_cnt_ff   <= vec_cnt_in;
         elem_cnt_ff  <= elem_cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_v_ff      <= item_v_in;
      item_e_ff      <= item_e_in;
      x_ff           <= x_in;
      end_vec_ff     <= end_vec_in;
      end_sample_ff  <= end_sample_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_is_pair_ff <= rsp_is_pair_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign busy             = (state_ff != pdi_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_is_pair      = rsp_is_pair_ff;
   assign rsp_last         = rsp_last_ff;

   a_no_rsp_while_mac: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdi_pkg::ST_MAC || state_ff == pdi_pkg::ST_DRAIN) |-> !rsp_valid_ff)
      else $error("result strobe during accumulation");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdi_pkg::ST_MAC) |-> (idx_ff < item_v_ff))
      else $error("accumulator index beyond current vector");

   a_emit_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdi_pkg::ST_EMIT) |-> !pipe_busy)
      else $error("pair emitted while products are still in flight");

   a_last_is_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_is_pair_ff)
      else $error("last marker on a dense result");

endmodule

// ===== rtl/pairwise_dot_interaction.sv =====
// Top level of the pairwise dot interaction block.
// Depends on pdi_pkg, pdi_seq, pdi_mac and pdi_ram.
//
// Usage: each sample is one dense vector followed by num_embeddings embedding
// vectors, each vector_width elements long, sent one element per request.
// A request is taken on a rising edge with start high and busy low; the
// element is on req_element_value (signed Q4.12).
// Results appear on the rsp_ ports for exactly one cycle with rsp_valid high.
// A dense element comes back in the cycle after its request, widened to Q24.24,
// and the block is ready again in the next cycle.
// An element of embedding vector n (n from 1) is multiplied against the same
// element of every earlier stored vector by one shared multiply-accumulate
// unit, one product per cycle through a three-stage pipeline, with busy high
// until it drains. The final element of a vector then emits the n dot
// products in order m = 0 to n-1, one per cycle; the final
// pair of the sample carries rsp_last.
// The receiver cannot stall; every strobe must be captured.
// Reset restores vector_width 16 and num_embeddings 26 and starts a new sample.
// Configuration writes through csr_we, csr_index and csr_wdata must be made only
// while busy is low (the block does not enforce it) and take effect on the next request.

module pairwise_dot_interaction (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pdi_pkg::DATA_W-1:0]          req_element_value,
   input  logic                                csr_we,
   input  logic [pdi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pdi_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   output logic [pdi_pkg::ACC_W-1:0]           rsp_result_value,
   output logic                                rsp_is_pair,
   output logic                                rsp_last
);

   logic                          ram_we;
   logic [pdi_pkg::ADDR_BITS-1:0] ram_waddr;
   logic [pdi_pkg::DATA_W-1:0]    ram_wdata;
   logic [pdi_pkg::ADDR_BITS-1:0] ram_raddr;
   logic [pdi_pkg::DATA_W-1:0]    ram_rdata;
   pdi_pkg::mac_ctrl_type         mac_ctrl;
   logic                          pipe_busy;
   logic [pdi_pkg::ACC_W-1:0]     acc_rdata;

   pdi_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_element_value (req_element_value),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .ram_we            (ram_we),
      .ram_waddr         (ram_waddr),
      .ram_wdata         (ram_wdata),
      .ram_raddr         (ram_raddr),
      .mac_ctrl          (mac_ctrl),
      .pipe_busy         (pipe_busy),
      .acc_rdata         (acc_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_result_value  (rsp_result_value),
      .rsp_is_pair       (rsp_is_pair),
      .rsp_last          (rsp_last)
   );

   pdi_ram #(
      .WIDTH (pdi_pkg::DATA_W),
      .DEPTH (pdi_pkg::STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pdi_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (mac_ctrl),
      .store_rdata (ram_rdata),
      .acc_rdata   (acc_rdata),
      .pipe_busy   (pipe_busy)
   );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for pairwise_dot_interaction: streams samples of dense and embedding
// elements, predicts the passthrough elements and pair dot products, and compares every strobe.
// Depends on pdi_pkg and the RTL under rtl only.

module tb;

   typedef struct packed {
      logic [pdi_pkg::ACC_W-1:0] value;
      logic                      is_pair;
      logic                      last;
   } interaction_result_type;

   class gram_scoreboard;
      logic [pdi_pkg::WIDTH_REG_W-1:0] width_reg;
      logic [pdi_pkg::NEMB_REG_W-1:0]  count_reg;
      logic [pdi_pkg::DATA_W-1:0]      store_mem [pdi_pkg::MAX_VECTORS][pdi_pkg::MAX_WIDTH];
      bit                              written [pdi_pkg::MAX_VECTORS][pdi_pkg::MAX_WIDTH];
      logic [pdi_pkg::ACC_W-1:0]       pair_sum [pdi_pkg::MAX_VECTORS];
      int unsigned                     elem_count;
      int unsigned                     vec_count;
      interaction_result_type          awaited_results [$];
      int                              errors;

      function new();
         width_reg = pdi_pkg::WIDTH_RESET;
         count_reg = pdi_pkg::NEMB_RESET;
         elem_count = 0;
         vec_count = 0;
         errors = 0;
         foreach (pair_sum[m]) pair_sum[m] = '0;
      endfunction

      function int unsigned effective_width(logic [pdi_pkg::WIDTH_REG_W-1:0] raw);
         if (raw == 0) return 1;
         if (raw > pdi_pkg::MAX_WIDTH) return pdi_pkg::MAX_WIDTH;
         return raw;
      endfunction

      function int unsigned effective_count(logic [pdi_pkg::NEMB_REG_W-1:0] raw);
         if (raw == 0) return 1;
         if (raw > pdi_pkg::MAX_VECTORS - 1) return pdi_pkg::MAX_VECTORS - 1;
         return raw;
      endfunction

      function void write_register(logic [pdi_pkg::CSR_IDX_W-1:0] index,
                                   logic [pdi_pkg::CSR_DATA_W-1:0] data);
         if (index == pdi_pkg::CSR_VECTOR_WIDTH)
            width_reg = data[pdi_pkg::WIDTH_REG_W-1:0];
         else if (index == pdi_pkg::CSR_NUM_EMBEDDINGS)
            count_reg = data[pdi_pkg::NEMB_REG_W-1:0];
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      function void add_expected(interaction_result_type item);
         awaited_results = {awaited_results, item};
      endfunction

      // Elements still due in the current sample under the present settings.
      function int unsigned items_left();
         int unsigned w;
         int unsigned ne;
         int unsigned rem;
         w = effective_width(width_reg);
         ne = effective_count(count_reg);
         rem = (elem_count >= w) ? 1 : w - elem_count;
         if (vec_count < ne) rem += (ne - vec_count) * w;
         return rem;
      endfunction

      // A new width must not make the block read a store entry that was never written.
      function bit widen_is_safe(logic [pdi_pkg::WIDTH_REG_W-1:0] raw);
         int unsigned w;
         w = effective_width(raw);
         for (int m = 0; m < vec_count; m++)
            for (int e = 0; e < w; e++)
               if (!written[m][e]) return 0;
         return 1;
      endfunction

      function void note_request(logic [pdi_pkg::DATA_W-1:0] x);
         int unsigned                     w;
         int unsigned                     ne;
         int unsigned                     v;
         int unsigned                     e;
         bit                              end_vec;
         bit                              end_sample;
         logic signed [pdi_pkg::ACC_W-1:0] prod;
         logic signed [pdi_pkg::ACC_W-1:0] wide;
         interaction_result_type          item;
         w = effective_width(width_reg);
         ne = effective_count(count_reg);
         v = (vec_count >= pdi_pkg::MAX_VECTORS) ? pdi_pkg::MAX_VECTORS - 1 : vec_count;
         e = (elem_count >= pdi_pkg::MAX_WIDTH) ? pdi_pkg::MAX_WIDTH - 1 : elem_count;
         store_mem[v][e] = x;
         written[v][e] = 1'b1;
         if (v == 0) begin
            wide = $signed(x);
            item.value = wide <<< pdi_pkg::FRAC_SHIFT;
            item.is_pair = 1'b0;
            item.last = 1'b0;
            add_expected(item);
         end else begin
            for (int m = 0; m < v; m++) begin
               prod = $signed(x) * $signed(store_mem[m][e]);
               pair_sum[m] = pair_sum[m] + prod;
            end
         end
         end_vec = (e + 1 >= w);
         end_sample = end_vec && (v >= ne);
         if (end_vec) begin
            for (int m = 0; m < v; m++) begin
               item.value = pair_sum[m];
               item.is_pair = 1'b1;
               item.last = end_sample && (m + 1 == v);
               add_expected(item);
               pair_sum[m] = '0;
            end
            elem_count = 0;
            vec_count = end_sample ? 0 : v + 1;
         end else begin
            elem_count = e + 1;
            vec_count = v;
         end
      endfunction

      function void check_response(logic [pdi_pkg::ACC_W-1:0] value, logic is_pair,
                                   logic last);
         interaction_result_type want;
         if (awaited_results.size() == 0) begin
            if (errors < 10)
               $display("unexpected result: value %0d pair %0b last %0b",
                        $signed(value), is_pair, last);
            errors++;
         end else begin
            want = awaited_results.pop_front();
            if (want.value !== value || want.is_pair !== is_pair || want.last !== last) begin
               if (errors < 10)
                  $display({"mismatch: expected value %0d pair %0b last %0b, ",
                            "got value %0d pair %0b last %0b"},
                           $signed(want.value), want.is_pair, want.last,
                           $signed(value), is_pair, last);
               errors++;
            end
         end
      endfunction
   endclass

   localparam int SETTLE_CYCLES = 70;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 90;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [pdi_pkg::DATA_W-1:0]        req_element_value = '0;
   logic                              csr_we = 1'b0;
   logic [pdi_pkg::CSR_IDX_W-1:0]     csr_index = pdi_pkg::CSR_VECTOR_WIDTH;
   logic [pdi_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;
   logic                              rsp_valid;
   logic [pdi_pkg::ACC_W-1:0]         rsp_result_value;
   logic                              rsp_is_pair;
   logic                              rsp_last;

   gram_scoreboard board;
   int                     sent_count = 0;
   int                     idle_pct = 37;
   int                     quiet_cycles = 0;

   pairwise_dot_interaction DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_element_value (req_element_value),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_result_value  (rsp_result_value),
      .rsp_is_pair       (rsp_is_pair),
      .rsp_last          (rsp_last)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) board.write_register(csr_index, csr_wdata);
         if (start && !busy) board.note_request(req_element_value);
         if (rsp_valid) board.check_response(rsp_result_value, rsp_is_pair, rsp_last);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [pdi_pkg::DATA_W-1:0] random_element();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_element(input logic [pdi_pkg::DATA_W-1:0] value);
      idle_pct = (sent_count < 78) ? 37 : (sent_count < 156) ? 54 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_element_value <= value;
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   task automatic send_random(input int unsigned count);
      for (int i = 0; i < count; i++) send_element(random_element());
   endtask

   task automatic quiesce();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(input logic [pdi_pkg::CSR_DATA_W-1:0] width_raw,
                                    input logic [pdi_pkg::CSR_DATA_W-1:0] count_raw);
      csr_we <= 1'b1;
      csr_index <= pdi_pkg::CSR_VECTOR_WIDTH;
      csr_wdata <= width_raw;
      @(posedge clock);
      csr_index <= pdi_pkg::CSR_NUM_EMBEDDINGS;
      csr_wdata <= count_raw;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [pdi_pkg::CSR_DATA_W-1:0] width_raw;
      logic [pdi_pkg::CSR_DATA_W-1:0] count_raw;
      int unsigned           sample_len;
      int unsigned           split;
      int unsigned           small_count;
      int                    random_start;
      int                    budget;
      int                    rest;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extreme elements, including the most negative product pair.
      program_registers(8'd2, 8'd2);
      send_element(16'h7FFF);
      send_element(16'h8000);
      send_element(16'h8000);
      send_element(16'h8000);
      send_element(16'h7FFF);
      send_element(16'hFFFF);
      quiesce();

      // Zero settings act as one element and one embedding.
      program_registers(8'd0, 8'd0);
      send_element(16'h0000);
      send_element(16'hFFFF);
      quiesce();

      // Mid-sample changes: the width drops below the element count, then the
      // embedding count drops below the vector count.
      program_registers(8'd3, 8'd3);
      send_random(5);
      quiesce();
      program_registers(8'd1, 8'd3);
      send_random(1);
      quiesce();
      program_registers(8'd1, 8'd1);
      send_random(1);
      quiesce();

      // Widest vectors: an out-of-range width acts as the maximum. The
      // embedding vector is then cut to a single element.
      program_registers(8'hFF, 8'h00);
      send_random(pdi_pkg::MAX_WIDTH);
      quiesce();
      program_registers(8'd1, 8'h00);
      send_random(1);
      quiesce();

      random_start = sent_count;
      program_registers(8'd1, 8'hFF);
      send_random(32);
      width_raw = 8'd1;
      count_raw = 8'hFF;
      while (sent_count - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            quiesce();
            width_raw = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
            small_count = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 31)
                                                      : $urandom_range(0, 4);
            count_raw = {3'($urandom), 5'(small_count)};
            program_registers(width_raw, count_raw);
         end
         budget = RANDOM_ITEMS - (sent_count - random_start);
         sample_len = board.effective_width(width_raw)
                      * (board.effective_count(count_raw[pdi_pkg::NEMB_REG_W-1:0]) + 1);
         if (sample_len > budget) sample_len = budget;
         if (sample_len > 1 && $urandom_range(0, 3) == 0) begin
            split = $urandom_range(1, sample_len - 1);
            send_random(split);
            quiesce();
            count_raw = {3'($urandom), 5'($urandom_range(0, 5))};
            if (board.widen_is_safe(8'($urandom_range(0, 6)))) begin
               width_raw = 8'($urandom_range(0, 6));
               if (!board.widen_is_safe(width_raw)) width_raw = 8'd1;
            end
            program_registers(width_raw, count_raw);
            budget = RANDOM_ITEMS - (sent_count - random_start);
            rest = int'(board.items_left());
            send_random((rest > budget) ? budget : rest);
         end else begin
            send_random(sample_len);
         end
      end
      quiesce();

      if (board.errors == 0 && board.pending() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
